>>> sv/otet_pkg.sv
// types and constants shared by the event trace ring
package otet_pkg;

    localparam int OP_W       = 2;
    localparam int TYPE_W     = 4;
    localparam int THREAD_W   = 16;
    localparam int WORD_W     = 64;
    localparam int OFFSET_W   = 7;
    localparam int COUNT_OUT_W = 8;

    typedef enum logic [OP_W-1:0] {
        OP_RECORD = 2'd0,
        OP_READ   = 2'd1,
        OP_CLEAR  = 2'd2
    } t_op;

    typedef struct packed {
        t_op                 op;
        logic [TYPE_W-1:0]   event_type;
        logic [THREAD_W-1:0] thread_id;
        logic [THREAD_W-1:0] other_thread_id;
        logic [WORD_W-1:0]   argument;
        logic [WORD_W-1:0]   timestamp;
        logic [OFFSET_W-1:0] read_offset;
    } t_in_item;

    typedef struct packed {
        logic                   entry_valid;
        logic [WORD_W-1:0]      sequence_number;
        logic [WORD_W-1:0]      entry_tick;
        logic [TYPE_W-1:0]      entry_type;
        logic [THREAD_W-1:0]    entry_thread;
        logic [THREAD_W-1:0]    entry_other_thread;
        logic [WORD_W-1:0]      entry_argument;
        logic [COUNT_OUT_W-1:0] stored_count;
        logic [WORD_W-1:0]      overwrite_total;
    } t_out_item;

endpackage

>>> sv/otet_ram.sv
// trace entry memory, one write port and one registered read port
module otet_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 228,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> sv/overwriting_event_trace_ring_core.sv
// overwriting event trace ring: top level with ring control and result register
//
// Holds up to CAPACITY trace entries in one synchronous memory. A record item
// writes its entry in the cycle it is accepted and overwrites the oldest entry
// once the ring is full; a clear item resets the pointers and counters. A read
// item looks the entry up in the memory at the accepting edge; its result is
// held there and loaded into the output register once that register is empty
// or being taken, and is then shown as the result item.
// One item is accepted per clock as long as the output register drains; a held
// result stalls input only once a second read is waiting behind it. No clearing
// pass is needed after reset: entries outside the stored count are never returned.
module overwriting_event_trace_ring_core #(
    parameter int CAPACITY        = 128,
    parameter int THREAD_ID_WIDTH = 16,
    parameter int TYPE_WIDTH      = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  otet_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output otet_pkg::t_out_item o_out_item
);

    localparam int PW  = $clog2(CAPACITY);
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int TSW = (TYPE_WIDTH < otet_pkg::TYPE_W) ? TYPE_WIDTH : otet_pkg::TYPE_W;
    localparam int ISW = (THREAD_ID_WIDTH < otet_pkg::THREAD_W) ?
                         THREAD_ID_WIDTH : otet_pkg::THREAD_W;
    localparam int WW  = otet_pkg::WORD_W;
    localparam int EW  = 3 * WW + TSW + 2 * ISW;
    localparam int XW  = (CW > otet_pkg::OFFSET_W) ? CW : otet_pkg::OFFSET_W;
    localparam int SW  = ((PW > otet_pkg::OFFSET_W) ? PW : otet_pkg::OFFSET_W) + 1;
    localparam int KW  = (CW > otet_pkg::COUNT_OUT_W) ? CW : otet_pkg::COUNT_OUT_W;

    logic [PW-1:0] r_oldest;
    logic [CW-1:0] r_count;
    logic [WW-1:0] r_next_seq;
    logic [WW-1:0] r_ovw;

    logic          r_pend;
    logic          r_pend_hit;
    logic [CW-1:0] r_pend_count;
    logic [WW-1:0] r_pend_ovw;

    logic                r_out_valid;
    otet_pkg::t_out_item r_out_item;

    logic          accept;
    logic          pend_move;
    logic          do_record;
    logic          do_read;
    logic          do_clear;
    logic          full;
    logic [PW:0]   rec_sum;
    logic [PW-1:0] rec_slot;
    logic [SW-1:0] rd_sum;
    logic [PW-1:0] rd_slot;
    logic          rd_hit;
    logic [EW-1:0] wr_data;
    logic [EW-1:0] rd_data;
    logic [KW-1:0] count_ext;

    logic [WW-1:0]  q_seq;
    logic [WW-1:0]  q_tick;
    logic [WW-1:0]  q_arg;
    logic [TSW-1:0] q_type;
    logic [ISW-1:0] q_thread;
    logic [ISW-1:0] q_other;

    assign pend_move  = r_pend && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_pend || !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        do_record = 1'b0;
        do_read   = 1'b0;
        do_clear  = 1'b0;
        case (i_in_item.op)
            otet_pkg::OP_RECORD: do_record = accept;
            otet_pkg::OP_READ:   do_read   = accept;
            otet_pkg::OP_CLEAR:  do_clear  = accept;
            default: ;
        endcase
    end

    assign full = (r_count == CW'(CAPACITY));

    always_comb begin
        rec_sum = {1'b0, r_oldest} + (PW + 1)'(r_count);
        if (full) begin
            rec_slot = r_oldest;
        end else if (rec_sum >= (PW + 1)'(CAPACITY)) begin
            rec_slot = PW'(rec_sum - (PW + 1)'(CAPACITY));
        end else begin
            rec_slot = rec_sum[PW-1:0];
        end
    end

    always_comb begin
        rd_hit = XW'(i_in_item.read_offset) < XW'(r_count);
        rd_sum = SW'(r_oldest) + SW'(i_in_item.read_offset);
        if (rd_sum >= SW'(CAPACITY)) begin
            rd_slot = PW'(rd_sum - SW'(CAPACITY));
        end else begin
            rd_slot = PW'(rd_sum);
        end
    end

    assign wr_data = {r_next_seq, i_in_item.timestamp, i_in_item.argument,
                      i_in_item.event_type[TSW-1:0], i_in_item.thread_id[ISW-1:0],
                      i_in_item.other_thread_id[ISW-1:0]};

    otet_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (EW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (do_record),
        .i_wr_addr (rec_slot),
        .i_wr_data (wr_data),
        .i_rd_en   (do_read),
        .i_rd_addr (rd_slot),
        .o_rd_data (rd_data)
    );

    assign {q_seq, q_tick, q_arg, q_type, q_thread, q_other} = rd_data;

    // ring pointers and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oldest   <= '0;
            r_count    <= '0;
            r_next_seq <= '0;
            r_ovw      <= '0;
        end else if (do_clear) begin
            r_oldest   <= '0;
            r_count    <= '0;
            r_next_seq <= '0;
            r_ovw      <= '0;
        end else if (do_record) begin
            r_next_seq <= r_next_seq + WW'(1);
            if (full) begin
                r_ovw <= r_ovw + WW'(1);
                if (r_oldest == PW'(CAPACITY - 1)) begin
                    r_oldest <= '0;
                end else begin
                    r_oldest <= r_oldest + PW'(1);
                end
            end else begin
                r_count <= r_count + CW'(1);
            end
        end
    end

    // read in flight and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (do_read) begin
                r_pend <= 1'b1;
            end else if (pend_move) begin
                r_pend <= 1'b0;
            end
            if (pend_move) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_read) begin
            r_pend_hit   <= rd_hit;
            r_pend_count <= r_count;
            r_pend_ovw   <= r_ovw;
        end
    end

    assign count_ext = KW'(r_pend_count);

    always_ff @(posedge i_clk) begin
        if (pend_move) begin
            r_out_item.entry_valid     <= r_pend_hit;
            r_out_item.stored_count    <= count_ext[otet_pkg::COUNT_OUT_W-1:0];
            r_out_item.overwrite_total <= r_pend_ovw;
            if (r_pend_hit) begin
                r_out_item.sequence_number    <= q_seq;
                r_out_item.entry_tick         <= q_tick;
                r_out_item.entry_argument     <= q_arg;
                r_out_item.entry_type         <= otet_pkg::TYPE_W'(q_type);
                r_out_item.entry_thread       <= otet_pkg::THREAD_W'(q_thread);
                r_out_item.entry_other_thread <= otet_pkg::THREAD_W'(q_other);
            end else begin
                r_out_item.sequence_number    <= '0;
                r_out_item.entry_tick         <= '0;
                r_out_item.entry_argument     <= '0;
                r_out_item.entry_type         <= '0;
                r_out_item.entry_thread       <= '0;
                r_out_item.entry_other_thread <= '0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

>>> sv/otet_checker.sv
// port-level checks for the event trace ring, bound to the top level
module otet_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input otet_pkg::t_in_item  i_in_item,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input otet_pkg::t_out_item o_out_item
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result item changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result item shown right after reset");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.entry_valid |->
            o_out_item.sequence_number == '0 && o_out_item.entry_tick == '0 &&
            o_out_item.entry_argument == '0 && o_out_item.entry_type == '0 &&
            o_out_item.entry_thread == '0 && o_out_item.entry_other_thread == '0)
        else $error("read beyond count returned nonzero entry fields");

    // read straight after clear with the result register empty
    a_empty_after_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_item.op == otet_pkg::OP_CLEAR ##1
        i_in_valid && o_in_ready && i_in_item.op == otet_pkg::OP_READ && !o_out_valid |->
        ##2 o_out_valid && !o_out_item.entry_valid && o_out_item.stored_count == '0 &&
            o_out_item.overwrite_total == '0)
        else $error("read straight after clear found stored entries");

endmodule

bind overwriting_event_trace_ring_core otet_checker u_otet_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);
